@@ hw/rtl/hashed_multiset_counter_unit_defines.svh @@
// Assertion macros shared by the multiset counter RTL.
`ifndef HASHED_MULTISET_COUNTER_UNIT_DEFINES_SVH
`define HASHED_MULTISET_COUNTER_UNIT_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge out of reset.
`define HMC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on every rising clock edge out of reset.
`define HMC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/hmc_pkg.sv @@
// Types, codes and helper functions of the hashed multiset counter.
package hmc_pkg;

  localparam int S_TDATA_W = 48;
  localparam int M_TDATA_W = 72;

  // Bucket index comes from the magnitude by a reciprocal multiply, then one correction.
  localparam int MAG_W       = 32;
  localparam int HASH_CYCLES = 2;
  localparam int HASH_CNT_W  = $clog2(HASH_CYCLES);

  typedef enum logic [1:0] {
    KIND_ADD    = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_QUERY  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_ABSENT   = 2'd1,
    STATUS_FULL     = 2'd2,
    STATUS_NEGATIVE = 2'd3
  } status_t;

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_HASH  = 5'b00100,
    ST_READ  = 5'b01000,
    ST_WRITE = 5'b10000
  } state_t;

  typedef struct packed {
    logic        valid;
    logic [31:0] value;
    logic [31:0] count;
  } slot_t;

  function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[32] ? 32'hFFFF_FFFF : sum[31:0];
  endfunction

endpackage

@@ hw/rtl/hashed_multiset_counter_unit.sv @@
// Hashed multiset counter: bucket rows of (valid, value, count) in one synchronous RAM.
// Each item passes the hash step (the reciprocal bucket remainder), the row read and the
// read-modify-write of the bucket row; the result is registered with the write-back, which
// stalls while an earlier result waits for m_tready. One item is in flight at a time.
// Reset (rst, synchronous): total cleared, then a clearing pass zeroes every row in turn
// while s_tready stays low.
module hashed_multiset_counter_unit #(
  parameter int BUCKETS = 64,
  parameter int WAYS    = 4
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [hmc_pkg::S_TDATA_W-1:0]  s_tdata,   // value[31:0], amount[47:32]
  input  logic [1:0]                     s_tuser,   // kind[1:0]
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [hmc_pkg::M_TDATA_W-1:0]  m_tdata,   // found[0], occurrences[32:1],
                                                    // total[64:33], zero fill [71:65]
  output logic [1:0]                     m_tuser    // status[1:0]
);
  import hmc_pkg::*;

  localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int WW = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam logic [BW:0]   BKT      = (BW + 1)'(BUCKETS);
  localparam logic [BW-1:0] LAST_ROW = BW'(BUCKETS - 1);
  localparam logic [31:0]   RECIP    = 32'(64'h1_0000_0000 / 64'(BUCKETS));

  state_t state;

  // Item registers
  logic [1:0]        kind;
  logic [31:0]       value;
  logic [15:0]       amount;
  logic [MAG_W-1:0]  mag;
  logic [2*MAG_W-1:0] prod;
  logic [HASH_CNT_W-1:0] hash_cnt;
  logic [BW-1:0]     bucket;
  logic [BW-1:0]     bucket_next;
  logic [BW-1:0]     clr_addr;
  logic [31:0]       total;

  // Bucket RAM
  slot_t [WAYS-1:0]  mem [BUCKETS];
  slot_t [WAYS-1:0]  rd_row;
  slot_t [WAYS-1:0]  new_row;
  logic              mem_we;
  logic [BW-1:0]     mem_waddr;
  slot_t [WAYS-1:0]  mem_wdata;

  // Update path
  logic              hit_found;
  logic [WW-1:0]     hit_idx;
  logic              free_found;
  logic [WW-1:0]     free_idx;
  logic [31:0]       amt_ext;
  logic [31:0]       total_next;
  status_t           status_next;
  logic              found_next;
  logic [31:0]       occ_next;
  logic              row_we;
  logic              wr_go;
  logic [31:0]       s_value;
  logic [15:0]       s_amount;

  assign s_value  = s_tdata[31:0];
  assign s_amount = s_tdata[47:32];
  assign s_tready = (state == ST_IDLE);
  assign wr_go    = (state == ST_WRITE) && (!m_tvalid || m_tready);

  // The reciprocal quotient is at most one low, so one compare and subtract finishes the
  // remainder; only the low bits of the difference are needed
  always_comb begin
    logic [BW:0] qb;
    logic [BW:0] rem;
    qb  = prod[MAG_W +: (BW + 1)] * BKT;
    rem = mag[BW:0] - qb;
    if (rem >= BKT) begin
      rem = rem - BKT;
    end
    bucket_next = rem[BW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
      total    <= '0;
      m_tvalid <= 1'b0;
      hash_cnt <= '0;
    end else begin
      if (wr_go) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == LAST_ROW) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (s_tvalid) begin
            hash_cnt <= '0;
            state    <= ST_HASH;
          end
        end
        ST_HASH: begin
          hash_cnt <= hash_cnt + 1'b1;
          if (hash_cnt == HASH_CNT_W'(HASH_CYCLES - 1)) begin
            state <= ST_READ;
          end
        end
        ST_READ: begin
          state <= ST_WRITE;
        end
        ST_WRITE: begin
          if (wr_go) begin
            total <= total_next;
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_CLEAR;
        end
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && s_tvalid) begin
      kind   <= s_tuser;
      value  <= s_value;
      amount <= s_amount;
      mag    <= s_value[31] ? (~s_value + 32'd1) : s_value;
    end else if (state == ST_HASH) begin
      prod <= {32'd0, mag} * {32'd0, RECIP};
      if (hash_cnt == HASH_CNT_W'(HASH_CYCLES - 1)) begin
        bucket <= bucket_next;
      end
    end
    if (wr_go) begin
      m_tuser <= status_next;
      m_tdata <= {7'd0, total_next, occ_next, found_next};
    end
  end

  // Lowest matching way and lowest free way of the row
  always_comb begin
    hit_found  = 1'b0;
    hit_idx    = '0;
    free_found = 1'b0;
    free_idx   = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (rd_row[w].valid && rd_row[w].value == value) begin
        hit_found = 1'b1;
        hit_idx   = WW'(w);
      end
      if (!rd_row[w].valid) begin
        free_found = 1'b1;
        free_idx   = WW'(w);
      end
    end
  end

  always_comb begin
    amt_ext     = {16'd0, amount};
    new_row     = rd_row;
    total_next  = total;
    status_next = STATUS_OK;
    found_next  = hit_found;
    row_we      = 1'b0;
    case (kind)
      KIND_ADD: begin
        if (amount[15]) begin
          status_next = STATUS_NEGATIVE;
        end else if (amount != 16'd0) begin
          if (hit_found) begin
            new_row[hit_idx].count = sat_add32(rd_row[hit_idx].count, amt_ext);
            total_next = sat_add32(total, amt_ext);
            row_we     = 1'b1;
          end else if (free_found) begin
            new_row[free_idx].valid = 1'b1;
            new_row[free_idx].value = value;
            new_row[free_idx].count = amt_ext;
            total_next = sat_add32(total, amt_ext);
            found_next = 1'b1;
            row_we     = 1'b1;
          end else begin
            status_next = STATUS_FULL;
          end
        end
      end
      KIND_REMOVE: begin
        if (!hit_found) begin
          status_next = STATUS_ABSENT;
        end else begin
          row_we = 1'b1;
          if (total != 32'd0) begin
            total_next = total - 32'd1;
          end
          if (rd_row[hit_idx].count <= 32'd1) begin
            new_row[hit_idx].valid = 1'b0;
            new_row[hit_idx].count = 32'd0;
            found_next = 1'b0;
          end else begin
            new_row[hit_idx].count = rd_row[hit_idx].count - 32'd1;
          end
        end
      end
      default: begin
        if (!hit_found) begin
          status_next = STATUS_ABSENT;
        end
      end
    endcase
    if (!found_next) begin
      occ_next = 32'd0;
    end else if (hit_found) begin
      occ_next = new_row[hit_idx].count;
    end else begin
      occ_next = new_row[free_idx].count;
    end
  end

  // Clearing pass owns the write port after reset; otherwise write back the row
  always_comb begin
    if (state == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr;
      mem_wdata = '0;
    end else begin
      mem_we    = wr_go && row_we;
      mem_waddr = bucket;
      mem_wdata = new_row;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_row <= mem[bucket];
  end

`include "hashed_multiset_counter_unit_defines.svh"

  `HMC_ASSERT_NEXT(a_result_follows_update, wr_go, m_tvalid, "no result after row update")
  `HMC_ASSERT_NEXT(a_total_only_on_update, !wr_go, $stable(total), "total moved without an update")
  `HMC_ASSERT_NOW(a_full_not_found, m_tvalid && m_tuser == STATUS_FULL, !m_tdata[0], "full bucket reported as found")
  `HMC_ASSERT_NOW(a_absent_zero_count, m_tvalid && !m_tdata[0], m_tdata[32:1] == 32'd0, "absent value with nonzero count")

endmodule
